// ===== rtl/psq_pkg.sv =====
`default_nettype none

package psq_pkg;

    // Default depth of the store
    localparam int CAPACITY_DEF = 16;

    // Field widths of the request and response items
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Cell index width, sized for the largest supported depth (64)
    localparam int IDX_W = 6;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd3;
    localparam logic [OP_W-1:0] OP_INS_AT    = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // Shift command broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;  // open a gap at idx, write value there
        logic             del;  // close the gap at idx
        logic [IDX_W-1:0] idx;
    } t_shift_ctl;

endpackage

`default_nettype wire

// ===== rtl/psq_req_if.sv =====
`default_nettype none

interface psq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic        [psq_pkg::OP_W-1:0]      operation;
    logic signed [psq_pkg::VALUE_W-1:0]   value;
    logic        [psq_pkg::POS_W-1:0]     position;

    modport source (output valid, operation, value, position, input ready);
    modport sink   (input valid, operation, value, position, output ready);
endinterface

`default_nettype wire

// ===== rtl/psq_rsp_if.sv =====
`default_nettype none

interface psq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic        [psq_pkg::STATUS_W-1:0]  status;
    logic        [psq_pkg::COUNT_W-1:0]   count;
    logic signed [psq_pkg::VALUE_W-1:0]   front_value;
    logic signed [psq_pkg::VALUE_W-1:0]   back_value;

    modport source (output valid, status, count, front_value, back_value, input ready);
    modport sink   (input valid, status, count, front_value, back_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/psq_cell.sv =====
`default_nettype none

// One chain cell; on a shift takes the new value or its left or right neighbor
module psq_cell #(
    parameter int IDX = 0
) (
    input  wire                               i_clk,
    input  wire psq_pkg::t_shift_ctl          i_ctl,
    input  wire logic [psq_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [psq_pkg::VALUE_W-1:0]  i_left,
    input  wire logic [psq_pkg::VALUE_W-1:0]  i_right,
    output logic      [psq_pkg::VALUE_W-1:0]  o_data
);

    localparam logic [psq_pkg::IDX_W-1:0] MY_IDX = psq_pkg::IDX_W'(IDX);

    logic [psq_pkg::VALUE_W-1:0] r_data;
    logic [psq_pkg::VALUE_W-1:0] n_data;

    // Insert: write at the gap, cells behind it take from the left.
    // Delete: the gap and cells behind it take from the right.
    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (MY_IDX == i_ctl.idx) begin
                n_data = i_value;
            end else if (MY_IDX > i_ctl.idx) begin
                n_data = i_left;
            end
        end else if (i_ctl.del) begin
            if (MY_IDX >= i_ctl.idx) begin
                n_data = i_right;
            end
        end
    end

    // Payload only, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== rtl/positional_sequence_store.sv =====
`default_nettype none

// Channel   Dir   Fields
// i_req     in    operation[2:0], value[31:0] signed, position[4:0]
// o_rsp     out   status[1:0], count[4:0], front_value[31:0], back_value[31:0]
//
// One item per cycle unless stalled: cells at and behind the position shift in the
// accept cycle, and the response appears from the output register in the next cycle.
// A held response stalls the request side; i_req.ready = !o_rsp.valid || o_rsp.ready.
// Reset (i_rst_n low, synchronous) empties the store; entry storage is not cleared.
// front_value and back_value are read from the cells while the response is held.
module positional_sequence_store #(
    parameter int CAPACITY = psq_pkg::CAPACITY_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    psq_req_if.sink   i_req,
    psq_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int BI_W  = $clog2(CAPACITY);
    localparam int CMP_W = ((CNT_W > psq_pkg::POS_W) ? CNT_W : psq_pkg::POS_W) + 1;

    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;
    logic                          r_valid;
    logic [psq_pkg::STATUS_W-1:0]  r_status;
    logic [psq_pkg::STATUS_W-1:0]  n_status;
    logic                          accept;
    logic                          full;
    logic [CMP_W-1:0]              pos_e;
    logic [CMP_W-1:0]              cnt_e;
    psq_pkg::t_shift_ctl           dec_ctl;
    psq_pkg::t_shift_ctl           ctl;
    logic [psq_pkg::VALUE_W-1:0]   cell_data [CAPACITY];
    logic [BI_W-1:0]               back_idx;
    logic [CNT_W+psq_pkg::COUNT_W-1:0] cnt_out;

    assign accept = i_req.valid && i_req.ready;
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign pos_e  = CMP_W'(i_req.position);
    assign cnt_e  = CMP_W'(r_count);

    // Operation decode: status, shift command and new count
    always_comb begin
        n_status = psq_pkg::ST_DONE;
        dec_ctl  = '0;
        n_count  = r_count;
        case (i_req.operation)
            psq_pkg::OP_INS_FRONT: begin
                if (full) begin
                    n_status = psq_pkg::ST_FULL;
                end else begin
                    dec_ctl.ins = 1'b1;
                    n_count     = r_count + CNT_W'(1);
                end
            end
            psq_pkg::OP_INS_BACK: begin
                if (full) begin
                    n_status = psq_pkg::ST_FULL;
                end else begin
                    dec_ctl.ins = 1'b1;
                    dec_ctl.idx = psq_pkg::IDX_W'(r_count);
                    n_count     = r_count + CNT_W'(1);
                end
            end
            psq_pkg::OP_DEL_FRONT: begin
                if (r_count == '0) begin
                    n_status = psq_pkg::ST_EMPTY;
                end else begin
                    dec_ctl.del = 1'b1;
                    n_count     = r_count - CNT_W'(1);
                end
            end
            psq_pkg::OP_DEL_BACK: begin
                if (r_count == '0) begin
                    n_status = psq_pkg::ST_EMPTY;
                end else begin
                    dec_ctl.del = 1'b1;
                    dec_ctl.idx = psq_pkg::IDX_W'(r_count - CNT_W'(1));
                    n_count     = r_count - CNT_W'(1);
                end
            end
            psq_pkg::OP_INS_AT: begin
                // position check wins over the full check
                if (pos_e == '0 || pos_e > cnt_e + CMP_W'(1)) begin
                    n_status = psq_pkg::ST_BADPOS;
                end else if (full) begin
                    n_status = psq_pkg::ST_FULL;
                end else begin
                    dec_ctl.ins = 1'b1;
                    dec_ctl.idx = psq_pkg::IDX_W'(i_req.position) - psq_pkg::IDX_W'(1);
                    n_count     = r_count + CNT_W'(1);
                end
            end
            psq_pkg::OP_DEL_AT: begin
                // delete at on an empty store is a bad position, not empty
                if (pos_e == '0 || pos_e > cnt_e) begin
                    n_status = psq_pkg::ST_BADPOS;
                end else begin
                    dec_ctl.del = 1'b1;
                    dec_ctl.idx = psq_pkg::IDX_W'(i_req.position) - psq_pkg::IDX_W'(1);
                    n_count     = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = psq_pkg::ST_BADPOS;
            end
        endcase
    end

    // Shift only on an accepted item
    always_comb begin
        ctl     = dec_ctl;
        ctl.ins = dec_ctl.ins && accept;
        ctl.del = dec_ctl.del && accept;
    end

    // Chain of cells, front at index 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [psq_pkg::VALUE_W-1:0] left_data;
        logic [psq_pkg::VALUE_W-1:0] right_data;

        if (g == 0) begin : g_first
            assign left_data = i_req.value;
        end else begin : g_mid_l
            assign left_data = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_data = cell_data[g];
        end else begin : g_mid_r
            assign right_data = cell_data[g+1];
        end

        psq_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_value (i_req.value),
            .i_left  (left_data),
            .i_right (right_data),
            .o_data  (cell_data[g])
        );
    end

    // Count and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
    end

    assign i_req.ready = !r_valid || o_rsp.ready;

    // Response fields; the cells hold still while the response waits
    assign back_idx          = BI_W'(r_count - CNT_W'(1));
    assign cnt_out           = (CNT_W + psq_pkg::COUNT_W)'(r_count);
    assign o_rsp.valid       = r_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.count       = cnt_out[psq_pkg::COUNT_W-1:0];
    assign o_rsp.front_value = (r_count == '0) ? '0 : cell_data[0];
    assign o_rsp.back_value  = (r_count == '0) ? '0 : cell_data[back_idx];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("store count above capacity");

    a_done_moves_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ((r_status == psq_pkg::ST_DONE) == (r_count != $past(r_count))))
        else $error("count change does not match status");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == psq_pkg::ST_EMPTY) |-> (r_count == '0))
        else $error("empty status with entries stored");
`endif

endmodule

`default_nettype wire

// ===== tb/psq_store_monitor.sv =====
`default_nettype none

// Watches both channels of the sequence store, keeps its own copy of the
// stored sequence and compares every response item with the prediction.
module psq_store_monitor
    import psq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    psq_req_if    i_req,
    psq_rsp_if    i_rsp,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_compared,
    output int    o_full_hits,
    output int    o_empty_hits,
    output int    o_badpos_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        [STATUS_W-1:0] status;
        logic        [COUNT_W-1:0]  count;
        logic signed [VALUE_W-1:0]  front_value;
        logic signed [VALUE_W-1:0]  back_value;
    } t_rsp_fields;

    // Shadow copy of the sequence, front first
    logic signed [VALUE_W-1:0] seq_cells [CAPACITY];
    int                        seq_len = 0;

    t_rsp_fields expected_responses [$];

    int fail_count  = 0;
    int compared    = 0;
    int full_hits   = 0;
    int empty_hits  = 0;
    int badpos_hits = 0;

    assign o_fail_count  = fail_count;
    assign o_pending     = expected_responses.size();
    assign o_compared    = compared;
    assign o_full_hits   = full_hits;
    assign o_empty_hits  = empty_hits;
    assign o_badpos_hits = badpos_hits;

    initial begin
        foreach (seq_cells[i]) seq_cells[i] = '0;
    end

    // Open a gap at idx and store the value there
    task automatic insert_cell(input int idx, input logic signed [VALUE_W-1:0] val);
        for (int i = seq_len; i > idx; i--) seq_cells[i] = seq_cells[i - 1];
        seq_cells[idx] = val;
        seq_len++;
    endtask

    // Close the gap at idx
    task automatic remove_cell(input int idx);
        for (int i = idx; i + 1 < seq_len; i++) seq_cells[i] = seq_cells[i + 1];
        seq_len--;
    endtask

    // Apply one request to the shadow sequence and build the response it causes
    task automatic apply_request(
        input  logic        [OP_W-1:0]    op,
        input  logic signed [VALUE_W-1:0] val,
        input  logic        [POS_W-1:0]   pos,
        output t_rsp_fields               rsp
    );
        logic is_full;
        int   p;
        is_full    = (seq_len >= CAPACITY);
        p          = int'(pos);
        rsp.status = ST_DONE;
        case (op)
            OP_INS_FRONT: begin
                if (is_full) rsp.status = ST_FULL;
                else insert_cell(0, val);
            end
            OP_INS_BACK: begin
                if (is_full) rsp.status = ST_FULL;
                else insert_cell(seq_len, val);
            end
            OP_DEL_FRONT: begin
                if (seq_len == 0) rsp.status = ST_EMPTY;
                else remove_cell(0);
            end
            OP_DEL_BACK: begin
                if (seq_len == 0) rsp.status = ST_EMPTY;
                else remove_cell(seq_len - 1);
            end
            OP_INS_AT: begin
                // position is checked before fullness
                if (p < 1 || p > seq_len + 1) rsp.status = ST_BADPOS;
                else if (is_full) rsp.status = ST_FULL;
                else insert_cell(p - 1, val);
            end
            OP_DEL_AT: begin
                if (p < 1 || p > seq_len) rsp.status = ST_BADPOS;
                else remove_cell(p - 1);
            end
            default: begin
                rsp.status = ST_BADPOS;
            end
        endcase
        rsp.count = COUNT_W'(seq_len);
        if (seq_len == 0) begin
            rsp.front_value = '0;
            rsp.back_value  = '0;
        end else begin
            rsp.front_value = seq_cells[0];
            rsp.back_value  = seq_cells[seq_len - 1];
        end
    endtask

    function automatic void check_field(
        input string                     name,
        input logic signed [VALUE_W-1:0] want,
        input logic signed [VALUE_W-1:0] got
    );
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Responses are matched first: a response never belongs to the request
    // accepted at the same edge
    always @(posedge i_clk) begin : watch
        t_rsp_fields oldest;
        t_rsp_fields predicted;
        if (i_rst_n) begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_responses.size() == 0) begin
                    $error("response item with no request pending");
                    fail_count++;
                end else begin
                    oldest = expected_responses.pop_front();
                    compared++;
                    check_field("status", oldest.status, i_rsp.status);
                    check_field("count", oldest.count, i_rsp.count);
                    check_field("front_value", oldest.front_value, i_rsp.front_value);
                    check_field("back_value", oldest.back_value, i_rsp.back_value);
                end
            end
            if (i_req.valid && i_req.ready) begin
                apply_request(i_req.operation, i_req.value, i_req.position, predicted);
                expected_responses.push_back(predicted);
                case (predicted.status)
                    ST_FULL:   full_hits++;
                    ST_EMPTY:  empty_hits++;
                    ST_BADPOS: badpos_hits++;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import psq_pkg::*;

    localparam int DEPTH            = CAPACITY_DEF;
    localparam int RANDOM_PER_PHASE = 250;

    // Codes outside the defined operation set
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int idle_pct  = 0;
    int stall_pct = 0;
    int sent      = 0;

    int fail_count, pending, compared, full_hits, empty_hits, badpos_hits;

    // Per phase: none, sender idle, receiver stall, both
    int phase_idle  [4] = '{0, 54, 0, 14};
    int phase_stall [4] = '{0, 0, 54, 14};

    logic signed [VALUE_W-1:0] corner_vals [6] = '{
        32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000,
        32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA
    };
    logic [OP_W-1:0] ins_ops [3] = '{OP_INS_FRONT, OP_INS_BACK, OP_INS_AT};
    logic [OP_W-1:0] del_ops [3] = '{OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT};

    psq_req_if req_ch ();
    psq_rsp_if rsp_ch ();

    positional_sequence_store #(
        .CAPACITY (DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    psq_store_monitor #(
        .CAPACITY (DEPTH)
    ) u_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_compared    (compared),
        .o_full_hits   (full_hits),
        .o_empty_hits  (empty_hits),
        .o_badpos_hits (badpos_hits)
    );

    always #4 i_clk = ~i_clk;

    // Run limit
    initial begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Response side backpressure
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Present one request item and hold it until accepted; valid stays high
    // into the next item unless an idle gap is chosen
    task automatic send_request(
        input logic        [OP_W-1:0]    op,
        input logic signed [VALUE_W-1:0] val,
        input logic        [POS_W-1:0]   pos
    );
        if ($urandom_range(99) < idle_pct) begin
            req_ch.valid     <= 1'b0;
            req_ch.operation <= OP_W'($urandom);
            req_ch.value     <= $urandom;
            req_ch.position  <= POS_W'($urandom);
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= val;
        req_ch.position  <= pos;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    initial begin
        int                        n;
        int                        r;
        int                        ph;
        int                        bias;
        int                        guard;
        logic        [OP_W-1:0]    op;
        logic signed [VALUE_W-1:0] val;
        logic        [POS_W-1:0]   pos;

        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_INS_FRONT;
        req_ch.value     <= '0;
        req_ch.position  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty store: front/back deletes report empty, all else a bad position
        send_request(OP_DEL_FRONT, 32'sh1234_5678, 5'd0);
        send_request(OP_DEL_BACK, 32'sh0, 5'd31);
        send_request(OP_DEL_AT, 32'sh0, 5'd1);
        send_request(OP_INS_AT, 32'sh7FFF_FFFF, 5'd0);
        send_request(OP_SPARE_6, 32'sh1, 5'd1);
        send_request(OP_SPARE_7, 32'sh1, 5'd1);

        // Fill to capacity with every insert flavor and the corner values
        for (n = 0; n < DEPTH; n++) begin
            case (n % 3)
                0:       op = OP_INS_FRONT;
                1:       op = OP_INS_BACK;
                default: op = OP_INS_AT;
            endcase
            if (op != OP_INS_AT) pos = POS_W'($urandom);
            else if (n == 2) pos = 5'd1;
            else if (n == 5) pos = POS_W'(n + 1);
            else pos = POS_W'($urandom_range(1, n + 1));
            val = (n < 12) ? corner_vals[n % 6] : $urandom;
            send_request(op, val, pos);
        end

        // Full store: refusals, a bad position winning over full, then two deletes
        send_request(OP_INS_BACK, 32'shFFFF_FFFF, 5'd0);
        send_request(OP_INS_AT, 32'sh0, 5'd31);
        send_request(OP_INS_AT, 32'sh0, POS_W'(DEPTH + 1));
        send_request(OP_DEL_AT, 32'sh0, POS_W'(DEPTH));
        send_request(OP_DEL_AT, 32'sh0, 5'd8);

        // Random traffic; the insert bias swings so the store reaches
        // both full and empty many times
        for (ph = 0; ph < 4; ph++) begin
            idle_pct  = phase_idle[ph];
            stall_pct <= phase_stall[ph];
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                bias = ((n / 40) % 2 == 0) ? 72 : 28;
                r = $urandom_range(99);
                if (r < 3) op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
                else if ($urandom_range(99) < bias) op = ins_ops[$urandom_range(2)];
                else op = del_ops[$urandom_range(2)];
                val = ($urandom_range(9) == 0) ? corner_vals[$urandom_range(5)] : $urandom;
                r = $urandom_range(99);
                if (r < 40) pos = POS_W'($urandom_range(0, 4));
                else if (r < 85) pos = POS_W'($urandom_range(0, DEPTH + 1));
                else pos = POS_W'($urandom_range(0, 31));
                send_request(op, val, pos);
            end
        end
        req_ch.valid <= 1'b0;

        // Drain, sampled away from the active edge
        guard = 0;
        do begin
            @(negedge i_clk);
            guard++;
        end while (pending != 0 && guard < 2000);
        repeat (4) @(negedge i_clk);

        if (pending != 0) $error("%0d expected response items never arrived", pending);

        $display("Sent %0d requests (directed corners, then random) through four idle/stall phases.",
                 sent);
        $display("Compared %0d responses: %0d full refusals, %0d empty no-ops, %0d bad positions.",
                 compared, full_hits, empty_hits, badpos_hits);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/psq_pkg.sv
rtl/psq_req_if.sv
rtl/psq_rsp_if.sv
rtl/psq_cell.sv
rtl/positional_sequence_store.sv
tb/psq_store_monitor.sv
tb/testbench.sv
